// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL. SYNTH removes them for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a property on every rising edge outside reset
`define LRMT_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check that a condition never holds outside reset
`define LRMT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define LRMT_ASSERT(lbl, clk, rstn, prop, msg)
`define LRMT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ----- rtl/core/lrmt_pkg.sv -----
`timescale 1ns / 1ps
package lrmt_pkg;

	localparam int VAL_W = 32;
	localparam int IDX_W = 10;
	localparam int OP_W  = 2;

	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 2'd0,
		OP_MAX   = 2'd1,
		OP_RAISE = 2'd2,
		OP_WRITE = 2'd3
	} op_t;

	// One tree node as stored in memory
	typedef struct packed {
		logic signed [VAL_W-1:0] max_v;
		logic signed [VAL_W-1:0] pend;
	} node_t;

	localparam int NODE_W = $bits(node_t);
	localparam node_t NODE_RST = '{max_v: VAL_MIN, pend: '0};

	// Result handed from the tree walker to the output stage
	typedef struct packed {
		logic signed [VAL_W-1:0] max_v;
		logic                    empty;
	} res_t;

	typedef enum logic [3:0] {
		W_CLEAR,
		W_IDLE,
		W_ENTER,
		W_EVAL,
		W_HD_RDL,
		W_HD_WRL,
		W_HD_WRR,
		W_HD_CLR,
		W_DESCEND,
		W_RET,
		W_GA_RDL,
		W_GA_RDR,
		W_GA_WR,
		W_FINISH
	} wstate_t;

	// Signed add that sticks at the 32-bit limits
	function automatic logic signed [VAL_W-1:0] sat_add(
		input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] d
	);
		logic signed [VAL_W:0] s;
		s = {a[VAL_W-1], a} + {d[VAL_W-1], d};
		if (s[VAL_W] != s[VAL_W-1]) begin
			return s[VAL_W] ? VAL_MIN : VAL_MAX;
		end
		return s[VAL_W-1:0];
	endfunction

	function automatic logic signed [VAL_W-1:0] smax(
		input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b
	);
		return (a > b) ? a : b;
	endfunction

	// Apply an add to both the maximum and the owed add of a node
	function automatic node_t give_add(input node_t n, input logic signed [VAL_W-1:0] d);
		node_t r;
		r.max_v = sat_add(n.max_v, d);
		r.pend  = sat_add(n.pend, d);
		return r;
	endfunction

endpackage

// ----- rtl/core/lrmt_ram.sv -----
`timescale 1ns / 1ps
module lrmt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/lrmt_walk.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lrmt_walk #(
	parameter int LEAF_COUNT = 1024,
	localparam int NW = $clog2(LEAF_COUNT) + 1
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic [lrmt_pkg::OP_W-1:0]              op,
	input  logic [lrmt_pkg::IDX_W-1:0]             first_index,
	input  logic [lrmt_pkg::IDX_W-1:0]             last_index,
	input  logic signed [lrmt_pkg::VAL_W-1:0]      amount,
	output logic                                   idle,
	output logic                                   res_valid,
	output lrmt_pkg::res_t                         res,
	input  logic                                   res_ready,
	output logic                                   ram_we,
	output logic [NW-1:0]                          ram_waddr,
	output logic [lrmt_pkg::NODE_W-1:0]            ram_wdata,
	output logic                                   ram_re,
	output logic [NW-1:0]                          ram_raddr,
	input  logic [lrmt_pkg::NODE_W-1:0]            ram_rdata
);
	import lrmt_pkg::*;

	localparam int IW  = $clog2(LEAF_COUNT);
	localparam int CW  = (IW > IDX_W) ? IW : IDX_W;
	localparam int SD  = IW;
	localparam int SPW = $clog2(SD + 1);
	localparam int SIW = (SD > 1) ? $clog2(SD) : 1;
	localparam logic [IW-1:0] TOP = IW'(LEAF_COUNT - 1);

	typedef struct packed {
		logic [NW-1:0] k;
		logic [IW-1:0] lo;
		logic [IW-1:0] hi;
		logic          rtodo;
	} frame_t;

	wstate_t state_q, state_nx;
	op_t     op_q;
	logic [CW-1:0] a_q, b_q;
	logic signed [VAL_W-1:0] amt_q, nmax_q, pend_q, lmax_q, best_q;
	logic empty_q;
	logic [NW-1:0] cur_k_q, clr_q;
	logic [IW-1:0] cur_lo_q, cur_hi_q;
	logic [SPW-1:0] sp_q;
	frame_t stack_q [SD];

	// Decode the incoming beat
	logic [CW-1:0] a_in, b_raw, b_in;
	logic is_range_in, work_in;
	assign a_in        = CW'(first_index);
	assign b_raw       = CW'(last_index);
	assign b_in        = (b_raw > CW'(TOP)) ? CW'(TOP) : b_raw;
	assign is_range_in = (op_t'(op) == OP_ADD) || (op_t'(op) == OP_MAX);
	assign work_in     = is_range_in ? (a_in <= b_in) : (a_in <= CW'(TOP));

	// Current node geometry
	logic [IW:0] sum_c;
	logic [IW-1:0] mid;
	logic is_range, covered, is_leaf, go_l, go_r;
	logic [NW-1:0] kl, kr;
	node_t node_rd;
	assign sum_c    = {1'b0, cur_lo_q} + {1'b0, cur_hi_q};
	assign mid      = sum_c[IW:1];
	assign is_range = (op_q == OP_ADD) || (op_q == OP_MAX);
	assign covered  = (a_q <= CW'(cur_lo_q)) && (CW'(cur_hi_q) <= b_q);
	assign is_leaf  = (cur_lo_q == cur_hi_q);
	assign go_l     = (a_q <= CW'(mid));
	assign go_r     = is_range ? (b_q > CW'(mid)) : !go_l;
	assign kl       = {cur_k_q[NW-2:0], 1'b0};
	assign kr       = {cur_k_q[NW-2:0], 1'b1};
	assign node_rd  = node_t'(ram_rdata);

	// Top of the return stack
	logic [SIW-1:0] top_idx;
	frame_t tf;
	logic [IW:0] tf_sum;
	logic [IW-1:0] tf_mid;
	assign top_idx = SIW'(sp_q - 1'b1);
	assign tf      = stack_q[top_idx];
	assign tf_sum  = {1'b0, tf.lo} + {1'b0, tf.hi};
	assign tf_mid  = tf_sum[IW:1];

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			W_CLEAR:   if (&clr_q) state_nx = W_IDLE;
			W_IDLE:    if (start) state_nx = work_in ? W_ENTER : W_FINISH;
			W_ENTER:   state_nx = W_EVAL;
			W_EVAL: begin
				if (is_range ? covered : is_leaf) state_nx = W_RET;
				else if (node_rd.pend != '0) state_nx = W_HD_RDL;
				else state_nx = W_DESCEND;
			end
			W_HD_RDL:  state_nx = W_HD_WRL;
			W_HD_WRL:  state_nx = W_HD_WRR;
			W_HD_WRR:  state_nx = W_HD_CLR;
			W_HD_CLR:  state_nx = W_DESCEND;
			W_DESCEND: state_nx = W_ENTER;
			W_RET: begin
				priority if (sp_q == '0) state_nx = W_FINISH;
				else if (tf.rtodo) state_nx = W_ENTER;
				else if (op_q != OP_MAX) state_nx = W_GA_RDL;
				else state_nx = W_RET;
			end
			W_GA_RDL:  state_nx = W_GA_RDR;
			W_GA_RDR:  state_nx = W_GA_WR;
			W_GA_WR:   state_nx = W_RET;
			W_FINISH:  if (res_ready) state_nx = W_IDLE;
			default:   state_nx = W_CLEAR;
		endcase
	end

	// Memory port and status outputs
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur_k_q;
		ram_wdata = NODE_W'(NODE_RST);
		ram_re    = 1'b0;
		ram_raddr = cur_k_q;
		unique case (state_q)
			W_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			W_ENTER: ram_re = 1'b1;
			W_EVAL: begin
				if (is_range) begin
					if (covered && op_q == OP_ADD) begin
						ram_we    = 1'b1;
						ram_wdata = give_add(node_rd, amt_q);
					end
				end else if (is_leaf) begin
					if (op_q == OP_WRITE) begin
						ram_we    = 1'b1;
						ram_wdata = {amt_q, {VAL_W{1'b0}}};
					end else if (amt_q > node_rd.max_v) begin
						ram_we    = 1'b1;
						ram_wdata = {amt_q, node_rd.pend};
					end
				end
			end
			W_HD_RDL: begin
				ram_re    = 1'b1;
				ram_raddr = kl;
			end
			W_HD_WRL: begin
				ram_we    = 1'b1;
				ram_waddr = kl;
				ram_wdata = give_add(node_rd, pend_q);
				ram_re    = 1'b1;
				ram_raddr = kr;
			end
			W_HD_WRR: begin
				ram_we    = 1'b1;
				ram_waddr = kr;
				ram_wdata = give_add(node_rd, pend_q);
			end
			W_HD_CLR: begin
				ram_we    = 1'b1;
				ram_wdata = {nmax_q, {VAL_W{1'b0}}};
			end
			W_GA_RDL: begin
				ram_re    = 1'b1;
				ram_raddr = kl;
			end
			W_GA_RDR: begin
				ram_re    = 1'b1;
				ram_raddr = kr;
			end
			W_GA_WR: begin
				ram_we    = 1'b1;
				ram_wdata = {smax(lmax_q, node_rd.max_v), {VAL_W{1'b0}}};
			end
			default: ;
		endcase
	end

	assign idle      = (state_q == W_IDLE);
	assign res_valid = (state_q == W_FINISH);
	assign res.max_v = (op_q == OP_MAX) ? best_q : '0;
	assign res.empty = empty_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_CLEAR;
			clr_q   <= '0;
			sp_q    <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == W_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == W_IDLE && start) sp_q <= '0;
			if (state_q == W_DESCEND) sp_q <= sp_q + 1'b1;
			if (state_q == W_RET && sp_q != '0 && !tf.rtodo) sp_q <= sp_q - 1'b1;
		end
	end

	// Walk datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			W_IDLE: begin
				if (start) begin
					op_q     <= op_t'(op);
					a_q      <= a_in;
					b_q      <= b_in;
					amt_q    <= amount;
					best_q   <= VAL_MIN;
					empty_q  <= (op_t'(op) == OP_MAX) && (a_in > b_in);
					cur_k_q  <= NW'(1);
					cur_lo_q <= '0;
					cur_hi_q <= TOP;
				end
			end
			W_EVAL: begin
				nmax_q <= node_rd.max_v;
				pend_q <= node_rd.pend;
				if (op_q == OP_MAX && covered) best_q <= smax(best_q, node_rd.max_v);
			end
			W_DESCEND: begin
				// push this node and step into the first child
				stack_q[SIW'(sp_q)] <= '{k: cur_k_q, lo: cur_lo_q, hi: cur_hi_q,
					rtodo: go_l && go_r};
				if (go_l) begin
					cur_k_q  <= kl;
					cur_hi_q <= mid;
				end else begin
					cur_k_q  <= kr;
					cur_lo_q <= mid + 1'b1;
				end
			end
			W_RET: begin
				if (sp_q != '0) begin
					if (tf.rtodo) begin
						stack_q[top_idx].rtodo <= 1'b0;
						cur_k_q  <= {tf.k[NW-2:0], 1'b1};
						cur_lo_q <= tf_mid + 1'b1;
						cur_hi_q <= tf.hi;
					end else begin
						cur_k_q <= tf.k;
					end
				end
			end
			W_GA_RDR: lmax_q <= node_rd.max_v;
			default: ;
		endcase
	end

	`LRMT_NEVER(a_no_rw_clash, clk, arst_n, ram_we && ram_re && ram_waddr == ram_raddr, "same entry read and written in one cycle")
	`LRMT_ASSERT(a_sp_bound, clk, arst_n, sp_q <= SPW'(SD), "return stack overflow")
	`LRMT_ASSERT(a_enter_span, clk, arst_n, state_q == W_ENTER |-> cur_lo_q <= cur_hi_q, "node span inverted")

endmodule

// ----- rtl/core/lazy_range_add_max_tree_core.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Lazy range-add / range-max tree over LEAF_COUNT signed 32-bit entries, one
// request at a time. All node maxima and owed adds live in one single-port-write,
// registered-read memory of 2 * 2**clog2(LEAF_COUNT) entries, and a walker
// steps the tree with a small return stack. Each visited node is read and
// decided, has any owed add pushed to its children, is stepped down from and
// returned to, and on updates gets its children recombined. After reset a
// clearing pass writes every entry before the first request is taken. A
// finished result waits in the output register while the next request is
// accepted.
module lazy_range_add_max_tree_core #(
	parameter int LEAF_COUNT = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [lrmt_pkg::OP_W-1:0]         op,
	input  logic [lrmt_pkg::IDX_W-1:0]        first_index,
	input  logic [lrmt_pkg::IDX_W-1:0]        last_index,
	input  logic signed [lrmt_pkg::VAL_W-1:0] amount,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [lrmt_pkg::VAL_W-1:0] max_found,
	output logic                              empty_range
);
	import lrmt_pkg::*;

	localparam int NW = $clog2(LEAF_COUNT) + 1;

	logic idle, start, res_valid, res_ready;
	res_t res;
	logic ram_we, ram_re;
	logic [NW-1:0] ram_waddr, ram_raddr;
	logic [NODE_W-1:0] ram_wdata, ram_rdata;
	logic out_valid_q;
	res_t out_q;

	assign in_ready  = idle;
	assign start     = in_valid && idle;
	assign res_ready = !out_valid_q || out_ready;

	lrmt_ram #(
		.WIDTH(NODE_W),
		.DEPTH(2 ** NW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	lrmt_walk #(
		.LEAF_COUNT(LEAF_COUNT)
	) u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.op         (op),
		.first_index(first_index),
		.last_index (last_index),
		.amount     (amount),
		.idle       (idle),
		.res_valid  (res_valid),
		.res        (res),
		.res_ready  (res_ready),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign max_found   = out_q.max_v;
	assign empty_range = out_q.empty;

	`LRMT_ASSERT(a_busy_after_start, clk, arst_n, in_valid && in_ready |=> !in_ready, "walker idle after accepting a beat")

endmodule
